/* hw/rtl/mis_pkg.sv */
//------------------------------------------------------------------------------
// mis_pkg
// Shared constants, types and codes of the maximum independent set search.
//------------------------------------------------------------------------------
package mis_pkg;

   localparam int MaxVertices  = 32;
   localparam int MaskWidth    = MaxVertices;
   localparam int IndexWidth   = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
   localparam int CountWidth   = 6;
   localparam int EdgeWidth    = 5;
   localparam int OutMaskWidth = 32;

   typedef logic [MaskWidth-1:0]  mask_type;
   typedef logic [CountWidth-1:0] count_type;
   typedef logic [EdgeWidth-1:0]  vert_type;

   typedef enum logic {
      CmdEdge  = 1'b0,
      CmdSolve = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      SeqIdle,
      SeqRun,
      SeqDrain,
      SeqHold
   } seq_state_type;

   typedef struct packed {
      logic      valid;
      logic      last;
      logic      conflict;
      count_type size;
      mask_type  cand;
   } stage_type;

   typedef struct packed {
      logic     en;
      logic     clear;
      vert_type u;
      vert_type v;
   } edge_wr_type;

   typedef struct packed {
      logic start;
      logic load;
   } seq_ctrl_type;

   typedef struct packed {
      logic tail_last;
      logic out_free;
   } seq_status_type;

endpackage

/* hw/rtl/mis_req_if.sv */
//------------------------------------------------------------------------------
// mis_req_if
// Request channel: edge and solve items with valid/ready handshake.
//------------------------------------------------------------------------------
interface mis_req_if;
   logic                           valid;
   logic                           ready;
   logic                           cmd;
   logic [mis_pkg::EdgeWidth-1:0]  edge_u;
   logic [mis_pkg::EdgeWidth-1:0]  edge_v;

   modport source (output valid, cmd, edge_u, edge_v, input ready);
   modport sink   (input valid, cmd, edge_u, edge_v, output ready);
endinterface

/* hw/rtl/mis_rsp_if.sv */
//------------------------------------------------------------------------------
// mis_rsp_if
// Response channel: chosen vertex mask and its size with valid/ready handshake.
//------------------------------------------------------------------------------
interface mis_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [mis_pkg::OutMaskWidth-1:0]  best_mask;
   logic [mis_pkg::CountWidth-1:0]    set_size;

   modport source (output valid, best_mask, set_size, input ready);
   modport sink   (input valid, best_mask, set_size, output ready);
endinterface

/* hw/rtl/mis_cell.sv */
//------------------------------------------------------------------------------
// mis_cell
// One vertex cell: holds the vertex's neighbor row and checks one candidate
// per cycle for a conflict on this vertex, then hands it to the next cell.
//------------------------------------------------------------------------------
module mis_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mis_pkg::IndexWidth-1:0] cell_index,
   input  mis_pkg::edge_wr_type          edge_wr,
   input  mis_pkg::stage_type            stage_i,
   output mis_pkg::stage_type            stage_o
);

   mis_pkg::mask_type  row_ff;
   mis_pkg::mask_type  row_in;
   mis_pkg::stage_type stage_ff;
   mis_pkg::stage_type stage_in;
   logic               take;

   always_comb begin
      row_in = row_ff;
      if (edge_wr.clear) begin
         row_in = '0;
      end else if (edge_wr.en) begin
         if (mis_pkg::CountWidth'(edge_wr.u) == mis_pkg::CountWidth'(cell_index)) begin
            row_in = row_in | (mis_pkg::mask_type'(1) << edge_wr.v);
         end
         if (mis_pkg::CountWidth'(edge_wr.v) == mis_pkg::CountWidth'(cell_index)) begin
            row_in = row_in | (mis_pkg::mask_type'(1) << edge_wr.u);
         end
      end

      take              = stage_i.cand[cell_index];
      stage_in          = stage_i;
      stage_in.conflict = stage_i.conflict | (take & (|(row_ff & stage_i.cand)));
      stage_in.size     = stage_i.size + mis_pkg::CountWidth'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff         <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         row_ff   <= row_in;
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

/* hw/rtl/mis_seq.sv */
//------------------------------------------------------------------------------
// mis_seq
// Sequencer: vertex count register, edge routing, subset enumeration into the
// cell chain, and result hand-off once the last subset leaves the chain.
//------------------------------------------------------------------------------
module mis_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [mis_pkg::CountWidth-1:0] csr_wr_data,
   input  logic                           req_valid,
   input  logic                           req_cmd,
   input  mis_pkg::vert_type              req_u,
   input  mis_pkg::vert_type              req_v,
   output logic                           req_ready,
   input  mis_pkg::seq_status_type        status,
   output mis_pkg::seq_ctrl_type          ctrl,
   output mis_pkg::edge_wr_type           edge_wr,
   output mis_pkg::stage_type             head
);

   mis_pkg::seq_state_type state_ff;
   mis_pkg::seq_state_type state_in;
   mis_pkg::count_type     vcount_ff;
   mis_pkg::count_type     vcount_in;
   mis_pkg::mask_type      cand_ff;
   mis_pkg::mask_type      cand_in;
   mis_pkg::mask_type      all_ff;
   mis_pkg::mask_type      all_in;
   mis_pkg::count_type     n;
   mis_pkg::mask_type      span;
   logic                   in_range;

   always_comb begin
      n = (vcount_ff > mis_pkg::CountWidth'(mis_pkg::MaxVertices))
          ? mis_pkg::CountWidth'(mis_pkg::MaxVertices) : vcount_ff;
      for (int i = 0; i < mis_pkg::MaskWidth; i++) begin
         span[i] = (mis_pkg::CountWidth'(i) < n);
      end
      in_range  = (mis_pkg::CountWidth'(req_u) < n) && (mis_pkg::CountWidth'(req_v) < n);
      vcount_in = csr_wr_en ? csr_wr_data : vcount_ff;
   end

   always_comb begin
      state_in      = state_ff;
      cand_in       = cand_ff;
      all_in        = all_ff;
      req_ready     = 1'b0;
      ctrl          = '0;
      edge_wr       = '0;
      edge_wr.u     = req_u;
      edge_wr.v     = req_v;
      head          = '0;
      head.cand     = cand_ff;

      unique case (state_ff)
         mis_pkg::SeqIdle: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == mis_pkg::CmdSolve) begin
                  ctrl.start = 1'b1;
                  cand_in    = '0;
                  all_in     = span;
                  state_in   = mis_pkg::SeqRun;
               end else begin
                  edge_wr.en = in_range;
               end
            end
         end
         mis_pkg::SeqRun: begin
            head.valid = 1'b1;
            head.last  = (cand_ff == all_ff);
            cand_in    = cand_ff + mis_pkg::mask_type'(1);
            if (head.last) begin
               state_in = mis_pkg::SeqDrain;
            end
         end
         mis_pkg::SeqDrain: begin
            if (status.tail_last) begin
               if (status.out_free) begin
                  ctrl.load     = 1'b1;
                  edge_wr.clear = 1'b1;
                  state_in      = mis_pkg::SeqIdle;
               end else begin
                  state_in = mis_pkg::SeqHold;
               end
            end
         end
         mis_pkg::SeqHold: begin
            if (status.out_free) begin
               ctrl.load     = 1'b1;
               edge_wr.clear = 1'b1;
               state_in      = mis_pkg::SeqIdle;
            end
         end
         default: begin
            state_in = mis_pkg::SeqIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mis_pkg::SeqIdle;
         vcount_ff <= '0;
      end else begin
         state_ff  <= state_in;
         vcount_ff <= vcount_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      all_ff  <= all_in;
   end

   a_last_in_drain: assert property (@(posedge clock) disable iff (reset)
      status.tail_last |-> state_ff == mis_pkg::SeqDrain)
      else $error("last subset left the chain outside drain");

   a_head_excl: assert property (@(posedge clock) disable iff (reset)
      head.valid |-> !req_ready)
      else $error("request taken while enumerating");

endmodule

/* hw/rtl/max_independent_set_bruteforce.sv */
//------------------------------------------------------------------------------
// max_independent_set_bruteforce
// Brute-force maximum independent set over a graph loaded by edge items.
//------------------------------------------------------------------------------
// A solve item feeds every subset of the first n vertices (n = the configured
// vertex count, at most 32) into a chain of 32 vertex cells, one subset per
// cycle from the candidate counter. The result is loaded into the output
// register once the last subset leaves the chain, and the next item can be
// taken in the cycle it is presented; if the previous result still waits in
// the output register, the solve holds until that one is taken. The result
// is the first independent subset of largest size in increasing order, after
// which the neighbor rows are cleared. Requests are held off for the whole
// solve.
//------------------------------------------------------------------------------
module max_independent_set_bruteforce (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [mis_pkg::CountWidth-1:0] csr_wr_data,
   mis_req_if.sink                        req_if,
   mis_rsp_if.source                      rsp_if
);

   mis_pkg::stage_type      chain [0:mis_pkg::MaxVertices];
   mis_pkg::stage_type      tail;
   mis_pkg::edge_wr_type    edge_wr;
   mis_pkg::seq_ctrl_type   ctrl;
   mis_pkg::seq_status_type status;

   mis_pkg::mask_type                 best_mask_ff;
   mis_pkg::mask_type                 best_mask_in;
   mis_pkg::count_type                best_count_ff;
   mis_pkg::count_type                best_count_in;
   logic                              rsp_valid_ff;
   logic [mis_pkg::OutMaskWidth-1:0]  rsp_mask_ff;
   mis_pkg::count_type                rsp_size_ff;

   mis_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_if.valid),
      .req_cmd     (req_if.cmd),
      .req_u       (req_if.edge_u),
      .req_v       (req_if.edge_v),
      .req_ready   (req_if.ready),
      .status      (status),
      .ctrl        (ctrl),
      .edge_wr     (edge_wr),
      .head        (chain[0])
   );

   for (genvar g = 0; g < mis_pkg::MaxVertices; g++) begin : g_cell
      mis_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (mis_pkg::IndexWidth'(g)),
         .edge_wr    (edge_wr),
         .stage_i    (chain[g]),
         .stage_o    (chain[g+1])
      );
   end

   assign tail = chain[mis_pkg::MaxVertices];

   always_comb begin
      best_mask_in  = best_mask_ff;
      best_count_in = best_count_ff;
      if (ctrl.start) begin
         best_mask_in  = '0;
         best_count_in = '0;
      end else if (tail.valid && !tail.conflict && (tail.size > best_count_ff)) begin
         best_mask_in  = tail.cand;
         best_count_in = tail.size;
      end
      status.tail_last = tail.valid & tail.last;
      status.out_free  = !rsp_valid_ff | rsp_if.ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_mask_ff  <= '0;
         best_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         best_mask_ff  <= best_mask_in;
         best_count_ff <= best_count_in;
         if (ctrl.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         rsp_mask_ff <= mis_pkg::OutMaskWidth'(best_mask_in);
         rsp_size_ff <= best_count_in;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.best_mask = rsp_mask_ff;
   assign rsp_if.set_size  = rsp_size_ff;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |=> rsp_if.valid)
      else $error("loaded item not presented");

   a_tail_size: assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> tail.size == mis_pkg::CountWidth'($countones(tail.cand)))
      else $error("chain size does not match candidate");

   a_best_size: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |-> best_count_in == mis_pkg::CountWidth'($countones(best_mask_in)))
      else $error("best size does not match best mask");

endmodule
